// ===== design/pcd_pkg.sv =====
// Shared types and constants of the polyline crossing detector.
// No dependencies.
`timescale 1ns / 1ps
package pcd_pkg;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int WIRE_BITS     = 8;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [CSR_IDX_BITS-1:0] REG_PARALLEL_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_ENDPOINT_MARGIN    = 2'd1;

   localparam logic [15:0] THRESHOLD_RESET = 16'd7;
   localparam logic [14:0] MARGIN_RESET    = 15'd7;

   typedef struct packed {
      logic [15:0] parallel_threshold;
      logic [14:0] endpoint_margin;
   } csr_type;

   typedef struct packed {
      logic frame_start;
      logic has_segment;
   } seg_flags_type;
endpackage

// ===== design/pcd_channels.sv =====
// Handshake channel interfaces for points in and crossings out.
// Depends on pcd_pkg.
`timescale 1ns / 1ps
interface pcd_req_if import pcd_pkg::*; #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic [WIRE_BITS-1:0]         wire_index;
   logic                         wire_start;
   logic                         frame_start;

   modport source (output valid, point_x, point_y, wire_index, wire_start, frame_start,
                   input ready);
   modport sink (input valid, point_x, point_y, wire_index, wire_start, frame_start,
                 output ready);
endinterface

interface pcd_rsp_if import pcd_pkg::*; #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] cross_x;
   logic signed [COORD_BITS-1:0] cross_y;
   logic [WIRE_BITS-1:0]         earlier_wire;
   logic [WIRE_BITS-1:0]         later_wire;
   logic                         store_full;
   logic                         last;

   modport source (output valid, cross_x, cross_y, earlier_wire, later_wire, store_full,
                   last, input ready);
   modport sink (input valid, cross_x, cross_y, earlier_wire, later_wire, store_full, last,
                 output ready);
endinterface

// ===== design/pcd_front.sv =====
// Front end: accepts points, tracks the previous point and forms segment jobs.
// Depends on pcd_pkg.
`timescale 1ns / 1ps
module pcd_front import pcd_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [COORD_BITS-1:0]             point_x,
   input  logic [COORD_BITS-1:0]             point_y,
   input  logic [WIRE_BITS-1:0]              wire_index,
   input  logic                              wire_start,
   input  logic                              frame_start,
   input  logic                              q_full,
   output logic                              q_push,
   output logic [4*COORD_BITS+WIRE_BITS+1:0] q_data
);
   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic [COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic                  have_prev_ff, have_prev_in;
   seg_flags_type         flags;

   assign in_ready = !q_full;
   assign q_push   = in_valid && !q_full;

   always_comb begin
      flags.frame_start = frame_start;
      flags.has_segment = have_prev_ff && !frame_start && !wire_start;
      prev_x_in         = q_push ? point_x : prev_x_ff;
      prev_y_in         = q_push ? point_y : prev_y_ff;
      have_prev_in      = q_push ? 1'b1 : have_prev_ff;
   end

   assign q_data = {flags, wire_index, prev_x_ff, prev_y_ff, point_x, point_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
      end else begin
         have_prev_ff <= have_prev_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
      end
   end
endmodule

// ===== design/pcd_queue.sv =====
// Short queue of segment jobs between front end and crossing engine.
// Depends on pcd_pkg.
`timescale 1ns / 1ps
module pcd_queue import pcd_pkg::*; #(
   parameter int WIDTH = 106
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             nonempty,
   output logic [WIDTH-1:0] head
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign nonempty = (cnt_ff != '0);
   assign head     = slot_ff[rd_ff];
   assign do_pop   = pop && nonempty;

   always_comb begin
      wr_in  = push ? PTR_W'((32'(wr_ff) + 1) % QUEUE_DEPTH) : wr_ff;
      rd_in  = do_pop ? PTR_W'((32'(rd_ff) + 1) % QUEUE_DEPTH) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule

// ===== design/pcd_back.sv =====
// Crossing engine: walks the segment store, runs the cross-product test,
// divides on hits and drives the result register. Depends on pcd_pkg.
`timescale 1ns / 1ps
module pcd_back import pcd_pkg::*; #(
   parameter int MAX_SEGMENTS = 64,
   parameter int COORD_BITS   = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  csr_type                           csr,
   input  logic                              q_valid,
   input  logic [4*COORD_BITS+WIRE_BITS+1:0] q_data,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [COORD_BITS-1:0]             cross_x,
   output logic [COORD_BITS-1:0]             cross_y,
   output logic [WIRE_BITS-1:0]              earlier_wire,
   output logic [WIRE_BITS-1:0]              later_wire,
   output logic                              store_full,
   output logic                              last
);
   localparam int CB     = COORD_BITS;
   localparam int DW     = CB + 1;
   localparam int PW     = 2 * DW;
   localparam int W      = PW + 1;
   localparam int K      = (W + 2) / 3;
   localparam int MW     = W + 17;
   localparam int RW     = W + 2;
   localparam int EW     = 4 * CB + WIRE_BITS;
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int IDX_W  = $clog2(MAX_SEGMENTS);
   localparam int STEP_W = $clog2(DW + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ISSUE = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_CROSS = 4'd4;
   localparam logic [3:0] S_MD    = 4'd5;
   localparam logic [3:0] S_TEST  = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;
   localparam logic [3:0] S_END   = 4'd9;

   logic [EW-1:0] mem [MAX_SEGMENTS];
   logic [EW-1:0] rd_data_ff;
   logic          mem_we;

   logic [3:0]           state_ff, state_in;
   logic [CB-1:0]        job_cx_ff, job_cx_in, job_cy_ff, job_cy_in;
   logic [CB-1:0]        job_px_ff, job_px_in, job_py_ff, job_py_in;
   logic [WIRE_BITS-1:0] job_wire_ff, job_wire_in;
   logic                 full_ff, full_in, ovf_ff, ovf_in;
   logic [CNT_W-1:0]     count_ff, count_in, idx_ff, idx_in;
   logic [CB-1:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic [WIRE_BITS-1:0] ewire_ff, ewire_in;
   logic signed [DW-1:0] rx_ff, rx_in, ry_ff, ry_in, sx_ff, sx_in, sy_ff, sy_in;
   logic signed [DW-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [PW-1:0] m_ff [6];
   logic signed [PW-1:0] m_in [6];
   logic signed [W-1:0]  den_ff, den_in, nt_ff, nt_in, nu_ff, nu_in;
   logic [K+14:0]        pp_ff [3];
   logic [K+14:0]        pp_in [3];
   logic                 par_ff, par_in, tneg_ff, tneg_in, uneg_ff, uneg_in;
   logic [RW-1:0]        rem_ff [2];
   logic [RW-1:0]        rem_in [2];
   logic [DW-1:0]        quo_ff [2];
   logic [DW-1:0]        quo_in [2];
   logic [DW-1:0]        mag_ff [2];
   logic [DW-1:0]        mag_in [2];
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [CB-1:0]        pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [WIRE_BITS-1:0] pend_ew_ff, pend_ew_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CB-1:0]        out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [WIRE_BITS-1:0] out_ew_ff, out_ew_in, out_lw_ff, out_lw_in;
   logic                 out_full_ff, out_full_in, out_last_ff, out_last_in;

   seg_flags_type        q_flags;
   logic [CB-1:0]        rd_ax, rd_ay, rd_bx, rd_by;
   logic [WIRE_BITS-1:0] rd_w;
   logic signed [W-1:0]  d_w, t_w, u_w;
   logic [3*K-1:0]       den_pad;
   logic [MW-1:0]        md, hi_lim, st, su;
   logic [RW-1:0]        den1, den2, ntr;
   logic [RW-1:0]        t_l [2];
   logic [1:0]           dig [2];
   logic [DW-1:0]        offx, offy;
   logic [CB-1:0]        hit_x, hit_y;
   logic [CNT_W-1:0]     cnt_clr;
   logic                 ovf_clr, out_free, hit;

   assign q_flags = q_data[EW+1:EW];
   assign rd_ax   = rd_data_ff[4*CB+WIRE_BITS-1 -: CB];
   assign rd_ay   = rd_data_ff[3*CB+WIRE_BITS-1 -: CB];
   assign rd_bx   = rd_data_ff[2*CB+WIRE_BITS-1 -: CB];
   assign rd_by   = rd_data_ff[CB+WIRE_BITS-1 -: CB];
   assign rd_w    = rd_data_ff[WIRE_BITS-1:0];

   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign mem_we    = (state_ff == S_ISSUE) && (idx_ff == count_ff)
                      && (count_ff < CNT_W'(MAX_SEGMENTS));

   assign rsp_valid    = out_valid_ff;
   assign cross_x      = out_x_ff;
   assign cross_y      = out_y_ff;
   assign earlier_wire = out_ew_ff;
   assign later_wire   = out_lw_ff;
   assign store_full   = out_full_ff;
   assign last         = out_last_ff;

   always_comb begin
      d_w     = m_ff[0] - m_ff[1];
      t_w     = m_ff[2] - m_ff[3];
      u_w     = m_ff[4] - m_ff[5];
      den_pad = (3*K)'($unsigned(den_ff));
      md      = MW'(pp_ff[0]) + (MW'(pp_ff[1]) << K) + (MW'(pp_ff[2]) << (2*K));
      hi_lim  = (MW'($unsigned(den_ff)) << 16) - md;
      st      = MW'($unsigned(nt_ff)) << 16;
      su      = MW'($unsigned(nu_ff)) << 16;
      hit     = !par_ff && !tneg_ff && !uneg_ff && (st > md) && (st < hi_lim)
                && (su > md) && (su < hi_lim);
      den1    = RW'($unsigned(den_ff));
      den2    = den1 << 1;
      ntr     = RW'($unsigned(nt_ff));
      for (int l = 0; l < 2; l++) begin
         t_l[l] = (rem_ff[l] << 1) + (mag_ff[l][DW-1] ? ntr : '0);
         if (t_l[l] >= den2) begin
            dig[l] = 2'd2;
         end else if (t_l[l] >= den1) begin
            dig[l] = 2'd1;
         end else begin
            dig[l] = 2'd0;
         end
      end
      offx    = rx_ff[DW-1] ? (~quo_ff[0] + 1'b1) : quo_ff[0];
      offy    = ry_ff[DW-1] ? (~quo_ff[1] + 1'b1) : quo_ff[1];
      hit_x   = ax_ff + offx[CB-1:0];
      hit_y   = ay_ff + offy[CB-1:0];
      cnt_clr = q_flags.frame_start ? '0 : count_ff;
      ovf_clr = q_flags.frame_start ? 1'b0 : ovf_ff;
   end

   always_comb begin
      state_in      = state_ff;
      job_cx_in     = job_cx_ff;
      job_cy_in     = job_cy_ff;
      job_px_in     = job_px_ff;
      job_py_in     = job_py_ff;
      job_wire_in   = job_wire_ff;
      full_in       = full_ff;
      ovf_in        = ovf_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      ewire_in      = ewire_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      m_in          = m_ff;
      den_in        = den_ff;
      nt_in         = nt_ff;
      nu_in         = nu_ff;
      pp_in         = pp_ff;
      par_in        = par_ff;
      tneg_in       = tneg_ff;
      uneg_in       = uneg_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      mag_in        = mag_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_ew_in    = pend_ew_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_ew_in     = out_ew_ff;
      out_lw_in     = out_lw_ff;
      out_full_in   = out_full_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               job_cy_in   = q_data[CB-1:0];
               job_cx_in   = q_data[2*CB-1:CB];
               job_py_in   = q_data[3*CB-1:2*CB];
               job_px_in   = q_data[4*CB-1:3*CB];
               job_wire_in = q_data[EW-1:4*CB];
               count_in    = cnt_clr;
               ovf_in      = ovf_clr;
               full_in     = ovf_clr || (cnt_clr == CNT_W'(MAX_SEGMENTS));
               idx_in      = '0;
               if (q_flags.has_segment) begin
                  state_in = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            if (idx_ff == count_ff) begin
               if (count_ff < CNT_W'(MAX_SEGMENTS)) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = S_END;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (rd_w == job_wire_ff) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_ISSUE;
            end else begin
               ax_in    = rd_ax;
               ay_in    = rd_ay;
               ewire_in = rd_w;
               rx_in    = {rd_bx[CB-1], rd_bx} - {rd_ax[CB-1], rd_ax};
               ry_in    = {rd_by[CB-1], rd_by} - {rd_ay[CB-1], rd_ay};
               sx_in    = {job_cx_ff[CB-1], job_cx_ff} - {job_px_ff[CB-1], job_px_ff};
               sy_in    = {job_cy_ff[CB-1], job_cy_ff} - {job_py_ff[CB-1], job_py_ff};
               qx_in    = {job_px_ff[CB-1], job_px_ff} - {rd_ax[CB-1], rd_ax};
               qy_in    = {job_py_ff[CB-1], job_py_ff} - {rd_ay[CB-1], rd_ay};
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            m_in[0]  = rx_ff * sy_ff;
            m_in[1]  = ry_ff * sx_ff;
            m_in[2]  = qx_ff * sy_ff;
            m_in[3]  = qy_ff * sx_ff;
            m_in[4]  = qx_ff * ry_ff;
            m_in[5]  = qy_ff * rx_ff;
            state_in = S_CROSS;
         end
         S_CROSS: begin
            if (d_w[W-1]) begin
               den_in = -d_w;
               nt_in  = -t_w;
               nu_in  = -u_w;
            end else begin
               den_in = d_w;
               nt_in  = t_w;
               nu_in  = u_w;
            end
            state_in = S_MD;
         end
         S_MD: begin
            for (int c = 0; c < 3; c++) begin
               pp_in[c] = (K+15)'(den_pad[c*K +: K]) * (K+15)'(csr.endpoint_margin);
            end
            par_in   = (den_ff == '0) || ($unsigned(den_ff) < W'(csr.parallel_threshold));
            tneg_in  = nt_ff[W-1];
            uneg_in  = nu_ff[W-1];
            state_in = S_TEST;
         end
         S_TEST: begin
            if (hit) begin
               mag_in[0] = rx_ff[DW-1] ? DW'(-rx_ff) : DW'(rx_ff);
               mag_in[1] = ry_ff[DW-1] ? DW'(-ry_ff) : DW'(ry_ff);
               rem_in[0] = '0;
               rem_in[1] = '0;
               quo_in[0] = '0;
               quo_in[1] = '0;
               step_in   = STEP_W'(DW);
               state_in  = S_DIV;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_DIV: begin
            if (step_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               for (int l = 0; l < 2; l++) begin
                  rem_in[l] = t_l[l] - (dig[l] == 2'd2 ? den2 : (dig[l] == 2'd1 ? den1 : '0));
                  quo_in[l] = (quo_ff[l] << 1) + DW'(dig[l]);
                  mag_in[l] = mag_ff[l] << 1;
               end
               step_in = step_ff - 1'b1;
            end
         end
         S_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_x_in     = pend_x_ff;
                  out_y_in     = pend_y_ff;
                  out_ew_in    = pend_ew_ff;
                  out_lw_in    = job_wire_ff;
                  out_full_in  = full_ff;
                  out_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_x_in     = hit_x;
               pend_y_in     = hit_y;
               pend_ew_in    = ewire_ff;
               idx_in        = idx_ff + 1'b1;
               state_in      = S_ISSUE;
            end
         end
         S_END: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_x_in      = pend_x_ff;
               out_y_in      = pend_y_ff;
               out_ew_in     = pend_ew_ff;
               out_lw_in     = job_wire_ff;
               out_full_in   = full_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= {job_px_ff, job_py_ff, job_cx_ff, job_cy_ff, job_wire_ff};
      end
      rd_data_ff <= mem[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      job_cx_ff   <= job_cx_in;
      job_cy_ff   <= job_cy_in;
      job_px_ff   <= job_px_in;
      job_py_ff   <= job_py_in;
      job_wire_ff <= job_wire_in;
      full_ff     <= full_in;
      idx_ff      <= idx_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      ewire_ff    <= ewire_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      m_ff        <= m_in;
      den_ff      <= den_in;
      nt_ff       <= nt_in;
      nu_ff       <= nu_in;
      pp_ff       <= pp_in;
      par_ff      <= par_in;
      tneg_ff     <= tneg_in;
      uneg_ff     <= uneg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      mag_ff      <= mag_in;
      step_ff     <= step_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      pend_ew_ff  <= pend_ew_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_ew_ff   <= out_ew_in;
      out_lw_ff   <= out_lw_in;
      out_full_ff <= out_full_in;
      out_last_ff <= out_last_in;
   end
endmodule

// ===== design/polyline_crossing_detector_unit.sv =====
// Top level of the polyline crossing detector: CSRs, front end, job queue, engine.
// Depends on pcd_pkg, pcd_channels, pcd_front, pcd_queue, pcd_back.
//
//   channel | direction | transaction
//   req_if  | in        | one polyline point with wire index and start flags
//   rsp_if  | out       | one crossing point with its wire pair
//   csr_*   | in        | register write, no handshake
//
// Per point the engine walks every stored segment: a segment of the same wire is
// skipped, a segment of another wire gets the cross-product test, and each crossing
// adds a bit-serial divide (both axes in parallel) before the point is closed.
// Throughput is bounded by the single engine walking the store one entry per read.
// Reset is synchronous; it empties the queue, the store and the result register.
// Either side may stall; the queue takes two points while the engine is busy.
`timescale 1ns / 1ps
module polyline_crossing_detector_unit import pcd_pkg::*; #(
   parameter int MAX_SEGMENTS = 64,
   parameter int COORD_BITS   = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   pcd_req_if.sink                  req_if,
   pcd_rsp_if.source                rsp_if,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);
   localparam int QW = 4 * COORD_BITS + WIRE_BITS + 2;

   csr_type       csr_ff, csr_in;
   logic          q_full, q_push, q_nonempty, q_pop;
   logic [QW-1:0] q_in_data, q_head;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PARALLEL_THRESHOLD: csr_in.parallel_threshold = csr_wdata;
            REG_ENDPOINT_MARGIN:    csr_in.endpoint_margin    = csr_wdata[14:0];
            default:                csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.parallel_threshold <= THRESHOLD_RESET;
         csr_ff.endpoint_margin    <= MARGIN_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   pcd_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_if.valid),
      .in_ready    (req_if.ready),
      .point_x     (req_if.point_x),
      .point_y     (req_if.point_y),
      .wire_index  (req_if.wire_index),
      .wire_start  (req_if.wire_start),
      .frame_start (req_if.frame_start),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_in_data)
   );

   pcd_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .nonempty  (q_nonempty),
      .head      (q_head)
   );

   pcd_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .COORD_BITS(COORD_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr_ff),
      .q_valid      (q_nonempty),
      .q_data       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .cross_x      (rsp_if.cross_x),
      .cross_y      (rsp_if.cross_y),
      .earlier_wire (rsp_if.earlier_wire),
      .later_wire   (rsp_if.later_wire),
      .store_full   (rsp_if.store_full),
      .last         (rsp_if.last)
   );
endmodule

// ===== design/pcd_checker.sv =====
// Port-level checks for the polyline crossing detector, bound to the top level.
// Depends on pcd_pkg and polyline_crossing_detector_unit.
`timescale 1ns / 1ps
module pcd_checker import pcd_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] cross_x,
   input logic [COORD_BITS-1:0] cross_y,
   input logic [WIRE_BITS-1:0]  earlier_wire,
   input logic [WIRE_BITS-1:0]  later_wire,
   input logic                  last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(cross_x) && $stable(cross_y) && $stable(last))
      else $error("rsp payload changed while stalled");

   a_wire_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> earlier_wire != later_wire)
      else $error("crossing reported within one wire");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");
endmodule

bind polyline_crossing_detector_unit pcd_checker #(.COORD_BITS(COORD_BITS)) u_pcd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .cross_x      (rsp_if.cross_x),
   .cross_y      (rsp_if.cross_y),
   .earlier_wire (rsp_if.earlier_wire),
   .later_wire   (rsp_if.later_wire),
   .last         (rsp_if.last)
);

// ===== bench/pcd_crossing_checker.sv =====
// Crossing checker: predicts crossings for every accepted point and compares
// each accepted crossing with the oldest prediction. Depends on pcd_pkg, pcd_channels.
`timescale 1ns / 1ps
module pcd_crossing_checker import pcd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   pcd_req_if                       req_if,
   pcd_rsp_if                       rsp_if,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       errors,
   output int                       pending
);
   typedef struct packed {
      logic signed [23:0] cross_x;
      logic signed [23:0] cross_y;
      logic [7:0]         earlier_wire;
      logic [7:0]         later_wire;
      logic               store_full;
      logic               last;
   } crossing_type;

   crossing_type       crossing_q[$];
   logic [15:0]        threshold;
   logic [14:0]        margin;
   logic signed [23:0] prev_x, prev_y;
   bit                 have_prev;
   logic signed [23:0] seg_ax[64], seg_ay[64], seg_bx[64], seg_by[64];
   logic [7:0]         seg_wire[64];
   int                 seg_count;
   bit                 overflow;

   initial errors = 0;
   initial pending = 0;

   function automatic bit param_ok(logic signed [127:0] num, logic signed [127:0] den);
      logic signed [127:0] m_lo, m_hi, scaled;
      m_lo = margin;
      m_hi = 65536 - m_lo;
      scaled = num <<< 16;
      return num >= 0 && scaled > den * m_lo && scaled < den * m_hi;
   endfunction

   task automatic predict_crossings(logic signed [23:0] x, logic signed [23:0] y,
                                    logic [7:0] wire_id, bit ws, bit fs);
      logic signed [127:0] rx, ry, sx, sy, qx, qy, den, nt, nu, ox, oy, thr;
      logic signed [23:0]  px, py;
      crossing_type        hits[$];
      crossing_type        c;
      if (fs) begin
         seg_count = 0;
         overflow = 0;
         have_prev = 0;
      end
      if (ws) have_prev = 0;
      if (have_prev) begin
         thr = threshold;
         for (int i = 0; i < seg_count; i++) begin
            if (seg_wire[i] == wire_id) continue;
            rx = seg_bx[i] - seg_ax[i];
            ry = seg_by[i] - seg_ay[i];
            sx = x - prev_x;
            sy = y - prev_y;
            qx = prev_x - seg_ax[i];
            qy = prev_y - seg_ay[i];
            den = rx * sy - ry * sx;
            nt = qx * sy - qy * sx;
            nu = qx * ry - qy * rx;
            if (den < 0) begin
               den = -den;
               nt = -nt;
               nu = -nu;
            end
            if (den == 0 || den < thr) continue;
            if (!param_ok(nt, den) || !param_ok(nu, den)) continue;
            ox = (nt * (rx < 0 ? -rx : rx)) / den;
            oy = (nt * (ry < 0 ? -ry : ry)) / den;
            px = 24'(seg_ax[i] + (rx < 0 ? -ox : ox));
            py = 24'(seg_ay[i] + (ry < 0 ? -oy : oy));
            c = '{px, py, seg_wire[i], wire_id, 1'b0, 1'b0};
            hits.push_back(c);
         end
         if (seg_count < 64) begin
            seg_ax[seg_count] = prev_x;
            seg_ay[seg_count] = prev_y;
            seg_bx[seg_count] = x;
            seg_by[seg_count] = y;
            seg_wire[seg_count] = wire_id;
            seg_count++;
         end else begin
            overflow = 1;
         end
         foreach (hits[k]) begin
            hits[k].store_full = overflow;
            hits[k].last = (k == hits.size() - 1);
            crossing_q.push_back(hits[k]);
         end
      end
      prev_x = x;
      prev_y = y;
      have_prev = 1;
   endtask

   always @(posedge clock) begin
      crossing_type got, want;
      if (reset) begin
         threshold <= THRESHOLD_RESET;
         margin <= MARGIN_RESET;
         prev_x = 0;
         prev_y = 0;
         have_prev = 0;
         seg_count = 0;
         overflow = 0;
         crossing_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_PARALLEL_THRESHOLD) threshold <= csr_wdata;
            else if (csr_index == REG_ENDPOINT_MARGIN) margin <= csr_wdata[14:0];
         end
         if (req_if.valid && req_if.ready)
            predict_crossings(req_if.point_x, req_if.point_y, req_if.wire_index,
                              req_if.wire_start, req_if.frame_start);
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.cross_x, rsp_if.cross_y, rsp_if.earlier_wire,
                    rsp_if.later_wire, rsp_if.store_full, rsp_if.last};
            if (crossing_q.size() == 0) begin
               if (errors < 10)
                  $display("unexpected crossing: x=%0d y=%0d wires %0d/%0d full=%0b last=%0b",
                           got.cross_x, got.cross_y, got.earlier_wire, got.later_wire,
                           got.store_full, got.last);
               errors++;
            end else begin
               want = crossing_q.pop_front();
               if (got !== want) begin
                  if (errors < 10)
                     $display({"crossing differs: expected x=%0d y=%0d wires %0d/%0d ",
                               "full=%0b last=%0b, got x=%0d y=%0d wires %0d/%0d ",
                               "full=%0b last=%0b"},
                              want.cross_x, want.cross_y, want.earlier_wire,
                              want.later_wire, want.store_full, want.last,
                              got.cross_x, got.cross_y, got.earlier_wire,
                              got.later_wire, got.store_full, got.last);
                  errors++;
               end
            end
         end
      end
      pending = crossing_q.size();
   end
endmodule

// ===== bench/tb.sv =====
// Testbench top: streams polyline frames into the crossing detector, varies the
// registers between phases and gives the verdict. Depends on pcd_pkg, pcd_channels,
// pcd_crossing_checker and the polyline_crossing_detector_unit RTL.
`timescale 1ns / 1ps
module tb;
   import pcd_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     csr_we = 0;
   logic [CSR_IDX_BITS-1:0]  csr_index = REG_PARALLEL_THRESHOLD;
   logic [CSR_DATA_BITS-1:0] csr_wdata = 0;
   int                       errors, pending;
   bit                       calm = 0;
   int                       quiet_cycles = 0;
   int                       points = 0;

   pcd_req_if #(.COORD_BITS(24)) req_if();
   pcd_rsp_if #(.COORD_BITS(24)) rsp_if();

   polyline_crossing_detector_unit #(.MAX_SEGMENTS(64), .COORD_BITS(24)) u_top (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pcd_crossing_checker u_checker (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   always #2 clock = ~clock;

   initial begin
      req_if.valid = 0;
      req_if.point_x = 0;
      req_if.point_y = 0;
      req_if.wire_index = 0;
      req_if.wire_start = 0;
      req_if.frame_start = 0;
      rsp_if.ready = 0;
   end

   always @(posedge clock) begin
      rsp_if.ready <= calm || $urandom_range(99) >= 11;
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("polyline_crossing_detector_unit: mismatch");
            $finish;
         end
      end
   end

   function automatic logic signed [23:0] rand_coord(int span);
      return 24'(int'($urandom_range(2 * span)) - span);
   endfunction

   task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
                             logic [7:0] wire_id, bit ws, bit fs);
      if (!calm && $urandom_range(99) < 11) begin
         req_if.valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 11);
      end
      req_if.valid <= 1;
      req_if.point_x <= x;
      req_if.point_y <= y;
      req_if.wire_index <= wire_id;
      req_if.wire_start <= ws;
      req_if.frame_start <= fs;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      points++;
   endtask

   task automatic send_frame(int wires, int max_pts, int span);
      logic [7:0] wire_id;
      int         n;
      wire_id = 8'($urandom_range(40));
      for (int w = 0; w < wires; w++) begin
         n = $urandom_range(max_pts, 2);
         for (int p = 0; p < n; p++)
            send_point(rand_coord(span), rand_coord(span), wire_id, p == 0, w == 0 && p == 0);
         wire_id = (wire_id > 250) ? wire_id : wire_id + 8'($urandom_range(3, 1));
      end
   endtask

   task automatic settle_and_write(logic [15:0] thr, logic [15:0] marg);
      req_if.valid <= 0;
      wait (pending == 0);
      repeat (1500) @(posedge clock);
      csr_we <= 1;
      csr_index <= REG_PARALLEL_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_index <= REG_ENDPOINT_MARGIN;
      csr_wdata <= marg;
      @(posedge clock);
      csr_we <= 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_point(-1000, -1000, 8'd0, 1, 1);
      send_point(1000, 1000, 8'd0, 0, 0);
      send_point(-1000, 1000, 8'd1, 1, 0);
      send_point(1000, -1000, 8'd1, 0, 0);
      send_point(-900, -1000, 8'd2, 1, 0);
      send_point(1100, 1000, 8'd2, 0, 0);
      send_point(1000, 1000, 8'd3, 1, 0);
      send_point(1000, -2000, 8'd3, 0, 0);
      send_point(5, 5, 8'd4, 1, 0);
      send_point(5, 5, 8'd4, 0, 0);
      send_point(-2000, 0, 8'd6, 0, 0);
      send_point(-1000, 0, 8'd200, 1, 1);
      send_point(1000, 0, 8'd200, 0, 0);
      send_point(0, -1000, 8'd3, 1, 0);
      send_point(0, 1000, 8'd3, 0, 0);
      send_point(-24'sd8388608, -24'sd8388608, 8'd255, 1, 1);
      send_point(24'sd8388607, 24'sd8388607, 8'd255, 0, 0);
      send_point(-24'sd8388608, 24'sd8388607, 8'd85, 1, 0);
      send_point(24'sd8388607, -24'sd8388608, 8'd85, 0, 0);
      send_point(3, 7, 8'd85, 0, 0);
      send_point(0, 0, 8'd170, 0, 1);
      send_point(-3000, 2000, 8'd170, 0, 0);

      settle_and_write(16'd0, 16'd0);
      calm = 1;
      repeat (2) send_frame(4, 4, 4000);
      calm = 0;
      repeat (2) send_frame(4, 3, 4000);

      settle_and_write(16'hFFFF, 16'h7FFF);
      repeat (2) send_frame(4, 3, 8000000);

      settle_and_write(16'($urandom_range(5000)), 16'($urandom));
      send_frame(6, 4, 3000);
      while (points < 100) begin
         if ($urandom_range(9) == 0)
            send_point(24'($urandom), 24'($urandom), 8'($urandom), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
         else
            send_frame(5, 4, 3000);
      end

      req_if.valid <= 0;
      wait (pending == 0);
      repeat (1500) @(posedge clock);
      if (errors == 0)
         $display("polyline_crossing_detector_unit: match");
      else
         $display("polyline_crossing_detector_unit: mismatch");
      $finish;
   end
endmodule
